// File: hw/rtl/hst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height-map solid triangulator package
// Shared widths, register indexes and the word types passed between parts.
// ----------------------------------------------------------------------------
package hst_pkg;

  localparam int POS_W   = 12;
  localparam int COORD_W = 26;
  localparam int HGT_W   = 24;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 24;

  localparam logic [CIDX_W-1:0] CFG_GRID_WIDTH   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_GRID_HEIGHT  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_NODATA_LEVEL = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_CELL_SCALE   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_BASE_LEVEL   = 3'd4;

  typedef struct packed {
    logic signed [HGT_W-1:0] sample;
    logic [POS_W-1:0]        x;
    logic [POS_W-1:0]        y;
    logic [1:0]              slot;
    logic                    x_last;
    logic                    y_last;
  } hst_job_t;

  typedef struct packed {
    logic signed [HGT_W-1:0] nodata;
    logic [15:0]             scale;
    logic signed [HGT_W-1:0] base;
  } hst_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]      ax;
    logic [COORD_W-1:0]      ay;
    logic signed [HGT_W-1:0] az;
    logic [COORD_W-1:0]      bx;
    logic [COORD_W-1:0]      by;
    logic signed [HGT_W-1:0] bz;
    logic [COORD_W-1:0]      cx;
    logic [COORD_W-1:0]      cy;
    logic signed [HGT_W-1:0] cz;
    logic [31:0]             count;
  } hst_tri_t;

endpackage

// File: hw/rtl/hst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hst_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 3072
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/hst_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Short FIFO between the front and the back part.
// ----------------------------------------------------------------------------
module hst_queue #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/hst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front part
// Accepts height words, tracks the grid position and queues one job each.
// ----------------------------------------------------------------------------
module hst_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [23:0]      height_sample_i,
  input  logic [10:0]             grid_width_i,
  input  logic [10:0]             grid_height_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output hst_pkg::hst_job_t       job_o
);
  import hst_pkg::*;

  logic [12:0]      eff_w, eff_h;
  logic [POS_W-1:0] wm1, hm1;
  logic [POS_W-1:0] col_q, row_q;
  logic [1:0]       slot_q;
  logic             restart;
  logic [POS_W-1:0] cur_x, cur_y;
  logic [1:0]       cur_slot;

  always_comb begin
    if (grid_width_i < 11'd2) begin
      eff_w = 13'd2;
    end else if ({2'b0, grid_width_i} > 13'(MAX_WIDTH)) begin
      eff_w = 13'(MAX_WIDTH);
    end else begin
      eff_w = {2'b0, grid_width_i};
    end
    if (grid_height_i < 11'd2) begin
      eff_h = 13'd2;
    end else if ({2'b0, grid_height_i} > 13'(MAX_HEIGHT)) begin
      eff_h = 13'(MAX_HEIGHT);
    end else begin
      eff_h = {2'b0, grid_height_i};
    end
  end

  assign wm1      = POS_W'(eff_w - 13'd1);
  assign hm1      = POS_W'(eff_h - 13'd1);
  assign restart  = (col_q > wm1) || (row_q > hm1);
  assign cur_x    = restart ? '0 : col_q;
  assign cur_y    = restart ? '0 : row_q;
  assign cur_slot = restart ? 2'd0 : slot_q;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    job_o.sample = height_sample_i;
    job_o.x      = cur_x;
    job_o.y      = cur_y;
    job_o.slot   = cur_slot;
    job_o.x_last = (cur_x == wm1);
    job_o.y_last = (cur_y == hm1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= 2'd0;
    end else if (push_o) begin
      if (cur_y == hm1) begin
        row_q <= '0;
        if (cur_x == wm1) begin
          col_q  <= '0;
          slot_q <= 2'd0;
        end else begin
          col_q  <= cur_x + 1'b1;
          slot_q <= (cur_slot == 2'd2) ? 2'd0 : cur_slot + 2'd1;
        end
      end else begin
        row_q  <= cur_y + 1'b1;
        col_q  <= cur_x;
        slot_q <= cur_slot;
      end
    end
  end

endmodule

// File: hw/rtl/hst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back part
// Stores each job's sample, loads its 3x3 window and emits the triangles of
// the cells that it completes.
// ----------------------------------------------------------------------------
module hst_back #(
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hst_pkg::hst_cfg_t       cfg_i,
  input  logic                    q_empty_i,
  input  hst_pkg::hst_job_t       job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output hst_pkg::hst_tri_t       tri_o,
  output logic                    last_o
);
  import hst_pkg::*;

  localparam int DEPTH = 3 * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_WR, S_RD, S_EVAL, S_CELL, S_TRI, S_END
  } state_e;

  function automatic logic [1:0] slot_add(input logic [1:0] s, input logic [1:0] n);
    logic [2:0] sum;
    sum = {1'b0, s} + {1'b0, n};
    if (sum >= 3'd3) begin
      sum = sum - 3'd3;
    end
    return sum[1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [1:0] s, input logic [POS_W-1:0] r);
    logic [AW-1:0] base;
    unique case (s)
      2'd1:    base = AW'(MAX_HEIGHT);
      2'd2:    base = AW'(2 * MAX_HEIGHT);
      default: base = '0;
    endcase
    return base + AW'(r);
  endfunction

  function automatic logic [3:0] pidx(input logic [3:0] p);
    return {1'b0, p[3:2], 1'b0} + {2'b0, p[3:2]} + {2'b0, p[1:0]};
  endfunction

  state_e state_q;
  logic [1:0]  ri_q, rj_q;
  logic [3:0]  rk_q;
  logic        cap_v_q;
  logic [3:0]  cidx_q;
  logic        ci_q, cj_q;
  logic        sec_q;
  logic [2:0]  k_q;
  logic        p_valid_q, out_valid_q, out_last_q;
  logic [31:0] cnt_q;

  logic signed [HGT_W-1:0] h_q [9];
  logic                    ed_q [9];
  logic                    n_q [9];
  logic                    e_q [9];
  logic [COORD_W-1:0]      xc_q [3];
  logic [COORD_W-1:0]      yc_q [3];
  logic                    sec_v_q [2];
  logic [3:0]              sec_p_q [2][3];
  hst_tri_t                pend_q, out_q;

  logic                    col_we, edge_we;
  logic [AW-1:0]           col_waddr, edge_waddr, raddr;
  logic [HGT_W-1:0]        col_rdata;
  logic                    edge_rdata;
  logic                    center_nd;

  logic [POS_W:0]          rsum;
  logic [POS_W-1:0]        rrow;
  logic [POS_W-1:0]        midx;
  logic [POS_W+15:0]       prod;

  logic                    nd_c [9];
  logic                    e_new [9];

  logic                    cell_ok, cell_last;
  logic [3:0]              pc, pr, pd, pf;
  logic                    nc, nr, nd, nf;
  logic                    s0v, s1v;
  logic [3:0]              s0p [3];
  logic [3:0]              s1p [3];

  logic [3:0]              pa, pb, v0, v1, v2;
  logic [2:0]              zb;
  logic                    tv, gen, out_free, sec_done, end_go, out_load;
  hst_tri_t                new_tri;

  // ---- memories
  assign col_we     = (state_q == S_WR);
  assign col_waddr  = addr_of(job_i.slot, job_i.y);
  assign edge_we    = (state_q == S_EVAL) && (job_i.x >= POS_W'(2)) && (job_i.y >= POS_W'(2));
  assign edge_waddr = addr_of(slot_add(job_i.slot, 2'd2), job_i.y - 1'b1);

  assign rsum  = {1'b0, job_i.y} + {{(POS_W - 1){1'b0}}, rj_q};
  assign rrow  = (rsum < (POS_W + 1)'(2)) ? '0 : POS_W'(rsum - (POS_W + 1)'(2));
  assign raddr = addr_of(slot_add(job_i.slot, ri_q + 2'd1), rrow);

  hst_ram #(.WIDTH(HGT_W), .DEPTH(DEPTH)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (job_i.sample),
    .raddr_i (raddr),
    .rdata_o (col_rdata)
  );

  hst_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (center_nd),
    .raddr_i (raddr),
    .rdata_o (edge_rdata)
  );

  // ---- window coordinates, one product per cycle
  always_comb begin
    if (rk_q < 4'd3) begin
      midx = job_i.x + POS_W'(rk_q) - POS_W'(2);
    end else begin
      midx = job_i.y + POS_W'(rk_q) - POS_W'(5);
    end
  end
  assign prod = midx * cfg_i.scale;

  // ---- window classification
  always_comb begin
    center_nd = 1'b0;
    for (int k = 0; k < 9; k++) begin
      nd_c[k]   = (h_q[k] == cfg_i.nodata);
      center_nd = center_nd | nd_c[k];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e_new[i * 3 + j] = (job_i.x == POS_W'(2 - i)) || (job_i.y == POS_W'(2 - j)) ||
                           ((i == 2) && job_i.x_last) || ((j == 2) && job_i.y_last) ||
                           ((i * 3 + j == 4) ? center_nd : ed_q[i * 3 + j]);
      end
    end
  end

  // ---- cell split
  always_comb begin
    pc = {1'b0, ci_q, 1'b0, cj_q};
    pr = {2'(ci_q) + 2'd1, 1'b0, cj_q};
    pd = {1'b0, ci_q, 2'(cj_q) + 2'd1};
    pf = {2'(ci_q) + 2'd1, 2'(cj_q) + 2'd1};
    nc = n_q[pidx(pc)];
    nr = n_q[pidx(pr)];
    nd = n_q[pidx(pd)];
    nf = n_q[pidx(pf)];
    cell_ok   = (ci_q ? (job_i.x >= POS_W'(1)) : (job_i.x >= POS_W'(2))) &&
                (cj_q ? (job_i.y >= POS_W'(1)) : (job_i.y >= POS_W'(2)));
    cell_last = (cj_q == job_i.y_last) && (ci_q == job_i.x_last);
    s0v = 1'b0;
    s1v = 1'b0;
    s0p[0] = pr; s0p[1] = pd; s0p[2] = pc;
    s1p[0] = pr; s1p[1] = pd; s1p[2] = pf;
    if (!nr && !nd) begin
      s0v = !nc;
      s1v = !nf;
    end else if (!nc && !nf) begin
      s0v    = !nr || !nd;
      s0p[0] = pf;
      s0p[1] = pc;
      s0p[2] = !nr ? pr : pd;
    end
  end

  // ---- triangle of the current step
  always_comb begin
    unique case (k_q[2:1])
      2'd1:    begin pa = sec_p_q[sec_q][0]; pb = sec_p_q[sec_q][1]; end
      2'd2:    begin pa = sec_p_q[sec_q][0]; pb = sec_p_q[sec_q][2]; end
      default: begin pa = sec_p_q[sec_q][1]; pb = sec_p_q[sec_q][2]; end
    endcase
    if (k_q[2:1] == 2'd0) begin
      v0 = sec_p_q[sec_q][0];
      v1 = sec_p_q[sec_q][1];
      v2 = sec_p_q[sec_q][2];
      zb = k_q[0] ? 3'b111 : 3'b000;
      tv = sec_v_q[sec_q];
    end else begin
      v0 = pa;
      v1 = k_q[0] ? pb : pa;
      v2 = pb;
      zb = k_q[0] ? 3'b011 : 3'b010;
      tv = sec_v_q[sec_q] && e_q[pidx(pa)] && e_q[pidx(pb)];
    end
    new_tri.ax    = xc_q[v0[3:2]];
    new_tri.ay    = yc_q[v0[1:0]];
    new_tri.az    = zb[0] ? cfg_i.base : h_q[pidx(v0)];
    new_tri.bx    = xc_q[v1[3:2]];
    new_tri.by    = yc_q[v1[1:0]];
    new_tri.bz    = zb[1] ? cfg_i.base : h_q[pidx(v1)];
    new_tri.cx    = xc_q[v2[3:2]];
    new_tri.cy    = yc_q[v2[1:0]];
    new_tri.cz    = zb[2] ? cfg_i.base : h_q[pidx(v2)];
    new_tri.count = cnt_q + 32'd1;
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign gen      = (state_q == S_TRI) && tv && (!p_valid_q || out_free);
  assign sec_done = (k_q == 3'd7) || !sec_v_q[sec_q];
  assign end_go   = (state_q == S_END) && (!p_valid_q || out_free);
  assign out_load = p_valid_q && (gen || end_go);
  assign pop_o    = end_go;

  assign out_valid_o = out_valid_q;
  assign tri_o       = out_q;
  assign last_o      = out_last_q;

  // ---- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ri_q        <= 2'd0;
      rj_q        <= 2'd0;
      rk_q        <= 4'd0;
      cap_v_q     <= 1'b0;
      ci_q        <= 1'b0;
      cj_q        <= 1'b0;
      sec_q       <= 1'b0;
      k_q         <= 3'd0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      cnt_q       <= '0;
    end else begin
      cap_v_q <= (state_q == S_RD) && (rk_q < 4'd9);
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_last_q  <= end_go;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (gen) begin
        p_valid_q <= 1'b1;
        cnt_q     <= cnt_q + 32'd1;
      end else if (end_go) begin
        p_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            state_q <= S_WR;
          end
        end
        S_WR: begin
          ri_q    <= 2'd0;
          rj_q    <= 2'd0;
          rk_q    <= 4'd0;
          state_q <= S_RD;
        end
        S_RD: begin
          if (rk_q == 4'd9) begin
            state_q <= S_EVAL;
          end else begin
            rk_q <= rk_q + 4'd1;
            if (rj_q == 2'd2) begin
              rj_q <= 2'd0;
              ri_q <= ri_q + 2'd1;
            end else begin
              rj_q <= rj_q + 2'd1;
            end
          end
        end
        S_EVAL: begin
          ci_q    <= 1'b0;
          cj_q    <= 1'b0;
          state_q <= S_CELL;
        end
        S_CELL: begin
          sec_q <= 1'b0;
          k_q   <= 3'd0;
          if (cell_ok) begin
            state_q <= S_TRI;
          end else if (cell_last) begin
            state_q <= S_END;
          end else if (cj_q != job_i.y_last) begin
            cj_q <= 1'b1;
          end else begin
            cj_q <= 1'b0;
            ci_q <= 1'b1;
          end
        end
        S_TRI: begin
          if (!tv || gen) begin
            if (sec_done) begin
              k_q <= 3'd0;
              if (!sec_q) begin
                sec_q <= 1'b1;
              end else if (cell_last) begin
                state_q <= S_END;
              end else begin
                state_q <= S_CELL;
                if (cj_q != job_i.y_last) begin
                  cj_q <= 1'b1;
                end else begin
                  cj_q <= 1'b0;
                  ci_q <= 1'b1;
                end
              end
            end else begin
              k_q <= k_q + 3'd1;
            end
          end
        end
        S_END: begin
          if (end_go) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---- payload
  always_ff @(posedge clk_i) begin
    if (cap_v_q) begin
      h_q[cidx_q]  <= col_rdata;
      ed_q[cidx_q] <= edge_rdata;
    end
    cidx_q <= pidx({ri_q, rj_q});
    if (state_q == S_RD) begin
      unique case (rk_q)
        4'd0:    xc_q[0] <= prod[COORD_W-1:0];
        4'd1:    xc_q[1] <= prod[COORD_W-1:0];
        4'd2:    xc_q[2] <= prod[COORD_W-1:0];
        4'd3:    yc_q[0] <= prod[COORD_W-1:0];
        4'd4:    yc_q[1] <= prod[COORD_W-1:0];
        4'd5:    yc_q[2] <= prod[COORD_W-1:0];
        default: ;
      endcase
    end
    if (state_q == S_EVAL) begin
      for (int k = 0; k < 9; k++) begin
        n_q[k] <= nd_c[k];
        e_q[k] <= e_new[k];
      end
    end
    if (state_q == S_CELL) begin
      sec_v_q[0] <= s0v;
      sec_v_q[1] <= s1v;
      for (int m = 0; m < 3; m++) begin
        sec_p_q[0][m] <= s0p[m];
        sec_p_q[1][m] <= s1p[m];
      end
    end
    if (gen) begin
      pend_q <= new_tri;
    end
    if (out_load) begin
      out_q <= pend_q;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !p_valid_q)
    else $error("pending triangle left over at idle");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> !p_valid_q)
    else $error("job retired with a triangle still pending");

  a_job_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |-> !q_empty_i)
    else $error("job started on an empty queue");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 32'd1))
    else $error("triangle count jumped");

endmodule

// File: hw/rtl/heightmap_solid_triangulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height-map solid triangulator
// Turns a stream of grid heights into the triangles of a closed solid.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+--------------------------
//   in       | in        | in_valid_i / in_stall_o  | height_sample_i
//   out      | out       | out_valid_o / out_stall_i| ax..cz, last_of_run,
//            |           |                          | triangles_so_far
//   cfg      | in        | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// In the back part a word stores its sample and loads its 3x3 window, then
// each candidate cell is checked, each cell section that holds a triangle
// steps through its candidate triangles, an empty section is passed over and
// the word is retired. Triangles go out one per cycle unless the output stalls.
// The front part keeps taking words into a two-entry queue meanwhile.
// Reset clears position, count and control; the sample store is not cleared.
// A stalled output holds the back part at the next triangle.
// ----------------------------------------------------------------------------
module heightmap_solid_triangulator_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] height_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [25:0]        ax_o,
  output logic [25:0]        ay_o,
  output logic signed [23:0] az_o,
  output logic [25:0]        bx_o,
  output logic [25:0]        by_coord_o,
  output logic signed [23:0] bz_o,
  output logic [25:0]        cx_o,
  output logic [25:0]        cy_o,
  output logic signed [23:0] cz_o,
  output logic               last_of_run_o,
  output logic [31:0]        triangles_so_far_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);
  import hst_pkg::*;

  logic [10:0]      grid_width_q, grid_height_q;
  hst_cfg_t         cfg_q;
  logic             push, pop, q_full, q_empty;
  hst_job_t         job_in, job_out;
  hst_tri_t         tri_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= 11'd1024;
      grid_height_q <= 11'd1024;
      cfg_q.nodata  <= 24'sh800000;
      cfg_q.scale   <= 16'd256;
      cfg_q.base    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_WIDTH:   grid_width_q  <= cfg_data_i[10:0];
        CFG_GRID_HEIGHT:  grid_height_q <= cfg_data_i[10:0];
        CFG_NODATA_LEVEL: cfg_q.nodata  <= cfg_data_i;
        CFG_CELL_SCALE:   cfg_q.scale   <= cfg_data_i[15:0];
        CFG_BASE_LEVEL:   cfg_q.base    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hst_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .height_sample_i (height_sample_i),
    .grid_width_i    (grid_width_q),
    .grid_height_i   (grid_height_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .job_o           (job_in)
  );

  hst_queue #(.WIDTH($bits(hst_job_t)), .DEPTH(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  hst_back #(.MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tri_o       (tri_w),
    .last_o      (last_of_run_o)
  );

  assign ax_o               = tri_w.ax;
  assign ay_o               = tri_w.ay;
  assign az_o               = tri_w.az;
  assign bx_o               = tri_w.bx;
  assign by_coord_o         = tri_w.by;
  assign bz_o               = tri_w.bz;
  assign cx_o               = tri_w.cx;
  assign cy_o               = tri_w.cy;
  assign cz_o               = tri_w.cz;
  assign triangles_so_far_o = tri_w.count;

endmodule

// File: dv/tb_heightmap_solid_triangulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Height-map solid triangulator testbench
// Feeds grids of height words, whole and cut off mid-grid, under changing
// register settings, with random gaps and stalls on both channels. Each
// accepted height word runs through a local mesh predictor. Its triangles are
// queued and checked field by field against every triangle the block emits.
// ----------------------------------------------------------------------------
module tb_heightmap_solid_triangulator_core;
  import hst_pkg::*;

  localparam int MAXH      = 1024;
  localparam int MAXW      = 1024;
  localparam int CYC_LIMIT = 1500000;
  localparam int SETTLE    = 400;

  typedef struct packed {
    logic [25:0] ax;
    logic [25:0] ay;
    logic [23:0] az;
    logic [25:0] bx;
    logic [25:0] by;
    logic [23:0] bz;
    logic [25:0] cx;
    logic [25:0] cy;
    logic [23:0] cz;
    logic        last;
    logic [31:0] count;
  } tri_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [23:0] height_sample_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [25:0]        ax_o, ay_o, bx_o, by_coord_o, cx_o, cy_o;
  logic signed [23:0] az_o, bz_o, cz_o;
  logic               last_of_run_o;
  logic [31:0]        triangles_so_far_o;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [23:0]        cfg_data_i;

  heightmap_solid_triangulator_core #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) dut (.*);

  // mesh predictor state
  logic [23:0] height_mem [3*MAXH];
  bit          edge_mem [3*MAXH];
  bit [10:0]   width_reg, height_reg;
  bit [23:0]   nodata_reg, base_reg;
  bit [15:0]   scale_reg;
  int          col_pos, row_pos, eff_w, eff_h;
  bit [31:0]   tri_count;

  logic [23:0] sample_q [$];
  tri_word_t   tri_q [$];
  int          idle_mode;
  int          errors;
  int          cycles;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  function automatic int slot(int x, int y);
    if (y >= MAXH) y = MAXH - 1;
    return (x % 3) * MAXH + y;
  endfunction

  function automatic bit is_nodata(int x, int y);
    return height_mem[slot(x, y)] == nodata_reg;
  endfunction

  function automatic bit is_edge(int x, int y);
    if (x == 0 || y == 0 || x == eff_w - 1 || y == eff_h - 1) return 1'b1;
    return edge_mem[slot(x, y)];
  endfunction

  function automatic logic [25:0] coord(int idx);
    return 26'(idx * int'(scale_reg));
  endfunction

  function automatic void push_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                                   logic [23:0] z0, logic [23:0] z1, logic [23:0] z2);
    tri_word_t t;
    tri_count++;
    t.ax = coord(x0); t.ay = coord(y0); t.az = z0;
    t.bx = coord(x1); t.by = coord(y1); t.bz = z1;
    t.cx = coord(x2); t.cy = coord(y2); t.cz = z2;
    t.last = 1'b0;
    t.count = tri_count;
    tri_q.push_back(t);
  endfunction

  function automatic void wall(int x1, int y1, int x2, int y2);
    logic [23:0] h1, h2;
    if (!is_edge(x1, y1) || !is_edge(x2, y2)) return;
    h1 = height_mem[slot(x1, y1)];
    h2 = height_mem[slot(x2, y2)];
    push_tri(x1, y1, x1, y1, x2, y2, h1, base_reg, h2);
    push_tri(x1, y1, x2, y2, x2, y2, base_reg, base_reg, h2);
  endfunction

  function automatic void facet(int x0, int y0, int x1, int y1, int x2, int y2);
    push_tri(x0, y0, x1, y1, x2, y2, height_mem[slot(x0, y0)],
             height_mem[slot(x1, y1)], height_mem[slot(x2, y2)]);
    push_tri(x0, y0, x1, y1, x2, y2, base_reg, base_reg, base_reg);
    wall(x0, y0, x1, y1);
    wall(x0, y0, x2, y2);
    wall(x1, y1, x2, y2);
  endfunction

  function automatic void split_cell(int x, int y);
    bit nr, nd, nc, nf;
    nr = is_nodata(x + 1, y);
    nd = is_nodata(x, y + 1);
    nc = is_nodata(x, y);
    nf = is_nodata(x + 1, y + 1);
    if (!nr && !nd) begin
      if (!nc) facet(x + 1, y, x, y + 1, x, y);
      if (!nf) facet(x + 1, y, x, y + 1, x + 1, y + 1);
    end else if (!nc && !nf) begin
      if (!nr) facet(x + 1, y + 1, x, y, x + 1, y);
      else if (!nd) facet(x + 1, y + 1, x, y, x, y + 1);
    end
  endfunction

  function automatic void mesh_step(logic [23:0] s);
    int x, y, xh, yh, n0;
    bit hole;
    eff_w = (width_reg < 2) ? 2 : (width_reg > MAXW) ? MAXW : int'(width_reg);
    eff_h = (height_reg < 2) ? 2 : (height_reg > MAXH) ? MAXH : int'(height_reg);
    n0 = tri_q.size();
    if (col_pos >= eff_w || row_pos >= eff_h) begin
      col_pos = 0;
      row_pos = 0;
    end
    x = col_pos;
    y = row_pos;
    height_mem[slot(x, y)] = s;
    if (x >= 2 && y >= 2) begin
      hole = 1'b0;
      for (int i = x - 2; i <= x; i++)
        for (int j = y - 2; j <= y; j++)
          if (is_nodata(i, j)) hole = 1'b1;
      edge_mem[slot(x - 1, y - 1)] = hole;
    end
    xh = (x == eff_w - 1) ? x - 1 : x - 2;
    yh = (y == eff_h - 1) ? y - 1 : y - 2;
    for (int cx = x - 2; cx <= xh; cx++)
      for (int cy = y - 2; cy <= yh; cy++)
        if (cx >= 0 && cy >= 0) split_cell(cx, cy);
    if (tri_q.size() > n0) tri_q[tri_q.size() - 1].last = 1'b1;
    row_pos = y + 1;
    if (row_pos >= eff_h) begin
      row_pos = 0;
      col_pos = x + 1;
      if (col_pos >= eff_w) col_pos = 0;
    end
  endfunction

  function automatic bit gap(bit is_sender);
    int pct;
    case (idle_mode)
      0: pct = is_sender ? 31 : 74;
      1: pct = is_sender ? 74 : 31;
      default: pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  // height driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      height_sample_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) mesh_step(height_sample_i);
      if (!in_valid_i || !in_stall_o) begin
        if (sample_q.size() > 0 && !gap(1'b1)) begin
          in_valid_i <= 1'b1;
          height_sample_i <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // triangle monitor
  always @(posedge clk_i or negedge rst_ni) begin
    tri_word_t got, want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= gap(1'b0);
      if (out_valid_o && !out_stall_i) begin
        got = '{ax_o, ay_o, az_o, bx_o, by_coord_o, bz_o, cx_o, cy_o, cz_o,
                last_of_run_o, triangles_so_far_o};
        if (tri_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected triangle, expected none, actual %p", $time, got);
        end else begin
          want = tri_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: triangle mismatch, expected %p, actual %p", $time, want, got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_GRID_WIDTH:   width_reg = val[10:0];
      CFG_GRID_HEIGHT:  height_reg = val[10:0];
      CFG_NODATA_LEVEL: nodata_reg = val;
      CFG_CELL_SCALE:   scale_reg = val[15:0];
      CFG_BASE_LEVEL:   base_reg = val;
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || in_valid_i || tri_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic setup(int w, int h, logic [23:0] nd, logic [15:0] sc, logic [23:0] bl);
    drain();
    cfg_write(CFG_GRID_WIDTH, 24'(w));
    cfg_write(CFG_GRID_HEIGHT, 24'(h));
    cfg_write(CFG_NODATA_LEVEL, nd);
    cfg_write(CFG_CELL_SCALE, 24'(sc));
    cfg_write(CFG_BASE_LEVEL, bl);
    cfg_done();
  endtask

  function automatic logic [23:0] rand_height(int hole_pct);
    if ($urandom_range(99) < hole_pct) return nodata_reg;
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800001;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic push_heights(int n, int hole_pct);
    for (int i = 0; i < n; i++) sample_q.push_back(rand_height(hole_pct));
  endtask

  task automatic random_phase(int n_items);
    int sent, w, h, pct;
    logic [15:0] sc;
    sent = 0;
    while (sent < n_items) begin
      w = $urandom_range(2, 8);
      h = $urandom_range(2, 8);
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(2, 3);
        h = $urandom_range(20, 60);
      end
      case ($urandom_range(3))
        0: sc = 16'h0000;
        1: sc = 16'hFFFF;
        default: sc = 16'($urandom);
      endcase
      setup(w, h, 24'($urandom), sc, 24'($urandom));
      pct = $urandom_range(0, 40);
      push_heights(w * h, pct);
      sent += w * h;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    height_sample_i = '0;
    out_stall_i = 1'b0;
    errors = 0;
    cycles = 0;
    idle_mode = 2;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    nodata_reg = 24'h800000;
    scale_reg = 16'd256;
    base_reg = 24'h000000;
    col_pos = 0;
    row_pos = 0;
    tri_count = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // clamped sizes, extreme scale and bottom level
    setup(1, 0, 24'h800000, 16'hFFFF, 24'h7FFFFF);
    sample_q = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h800001,
                 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800001};
    // no-data split cases
    setup(4, 4, 24'h000000, 16'h0000, 24'h800000);
    sample_q = '{24'd5, 24'd0, 24'd7, 24'd9, 24'd0, 24'd3, 24'd4, 24'd2,
                 24'd6, 24'd8, 24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd0};
    // shrink mid-grid to restart at the origin
    setup(8, 8, 24'h800000, 16'd256, 24'h000000);
    push_heights(27, 15);
    drain();
    cfg_write(CFG_GRID_WIDTH, 24'd2);
    cfg_done();
    push_heights(16, 15);

    idle_mode = 0;
    random_phase(90);
    drain();
    idle_mode = 1;
    random_phase(90);
    drain();
    idle_mode = 2;
    random_phase(90);
    drain();

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/hst_pkg.sv
hw/rtl/hst_ram.sv
hw/rtl/hst_queue.sv
hw/rtl/hst_front.sv
hw/rtl/hst_back.sv
hw/rtl/heightmap_solid_triangulator_core.sv
dv/tb_heightmap_solid_triangulator_core.sv
